[rtl/bpe_pkg.sv]
// Shared types and constants for the Bezier patch point evaluator.
package bpe_pkg;
   localparam int unsigned CoordWidth = 32;
   localparam int unsigned ParamWidth = 17;
   localparam int unsigned FracBits   = 16;
   localparam int unsigned MaxRows    = 4;
   localparam int unsigned MaxCols    = 4;
   localparam logic [ParamWidth-1:0] OneQ16 = 17'h10000;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_EVAL  = 1'b1
   } op_type;

   localparam logic [0:0] CSR_ROWS = 1'b0;
   localparam logic [0:0] CSR_COLS = 1'b1;

   typedef logic signed [CoordWidth-1:0] coord_type;
endpackage

[rtl/bpe_lerp.sv]
// Signed lerp unit with registered products: ((1-t)*a + t*b) >>> 16.
module bpe_lerp (
   input  logic                        clock,
   input  logic [bpe_pkg::ParamWidth-1:0] t,
   input  bpe_pkg::coord_type          a,
   input  bpe_pkg::coord_type          b,
   output bpe_pkg::coord_type          y
);
   import bpe_pkg::*;

   logic signed [49:0] pa_ff, pb_ff;
   logic signed [50:0] sum;
   logic signed [17:0] ta, tb;

   // one minus t and t, as signed 18-bit factors
   assign ta = $signed({1'b0, OneQ16 - t});
   assign tb = $signed({1'b0, t});

   // register products, then add and shift
   always_ff @(posedge clock) begin
      pa_ff <= ta * a;
      pb_ff <= tb * b;
   end

   assign sum = {pa_ff[49], pa_ff} + {pb_ff[49], pb_ff};
   assign y   = sum[FracBits +: CoordWidth];
endmodule

[rtl/bezier_patch_point_eval_unit.sv]
// Top level of the Bezier patch point evaluator.
// Input channel req_*: operation OP_WRITE stores one control point at
// (row_index, col_index); OP_EVAL evaluates the patch at (u_param, v_param).
// Result channel rsp_*: one surface point per evaluate, none per write.
// A write is stored at its accepting edge; writes can follow back to back.
// An evaluate copies each row from the control point memory (one read per
// cycle, registered read) into a small work file, then reduces it on one
// shared lerp unit, one coordinate at a time, waiting for each coordinate's
// lerp to land before issuing the next. No new request is accepted while
// an evaluate runs; the block is ready again once the result is registered.
// The cost is set by the single lerp unit and the single memory read port.
// The result sits in an output register; while the receiver stalls, writes
// are still accepted and a following evaluate waits before its last step.
// Reset clears control state and sets both counts to their maximum; the
// memory holds its contents undefined until written. csr_* writes take
// effect at once; the user must make them only while idle, as the block
// itself does not enforce this.
module bezier_patch_point_eval_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_operation,
   input  logic [1:0]                     req_row_index,
   input  logic [1:0]                     req_col_index,
   input  bpe_pkg::coord_type             req_coord_x,
   input  bpe_pkg::coord_type             req_coord_y,
   input  bpe_pkg::coord_type             req_coord_z,
   input  logic [bpe_pkg::ParamWidth-1:0] req_u_param,
   input  logic [bpe_pkg::ParamWidth-1:0] req_v_param,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bpe_pkg::coord_type             rsp_point_x,
   output bpe_pkg::coord_type             rsp_point_y,
   output bpe_pkg::coord_type             rsp_point_z,
   input  logic                           csr_write_enable,
   input  logic                           csr_index,
   input  logic [2:0]                     csr_write_data
);
   import bpe_pkg::*;

   localparam int unsigned Depth = MaxRows * MaxCols;
   localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned RowW  = (MaxRows > 1) ? $clog2(MaxRows) : 1;
   localparam int unsigned WorkN = (MaxRows > MaxCols) ? MaxRows : MaxCols;
   localparam int unsigned NumW  = $clog2(WorkN + 1);
   localparam int unsigned WIdxW = (WorkN > 1) ? $clog2(WorkN) : 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_REDUCE, ST_WAIT, ST_ROWDONE, ST_FINAL, ST_OUT
   } state_type;

   // control point memory, x/y/z side by side
   logic [3*CoordWidth-1:0] mem [Depth];
   logic [3*CoordWidth-1:0] rd_ff;

   // work files: one for the current row, one for the row points
   coord_type wx_ff [WorkN][3];
   coord_type rp_ff [MaxRows][3];

   state_type              state_ff;
   logic [2:0]             rows_ff, cols_ff;
   logic [ParamWidth-1:0]  u_ff, v_ff;
   logic [NumW-1:0]        nr_ff, nc_ff;
   logic [NumW-1:0]        row_ff;      // current row being reduced
   logic [NumW-1:0]        ld_ff;       // load counter (issued reads)
   logic                   ld_v_ff;     // read data valid in rd_ff
   logic [WIdxW-1:0]       ld_dst_ff;
   logic [NumW-1:0]        len_ff;      // current reduction length
   logic [WIdxW-1:0]       i_ff;        // lerp index
   logic [1:0]             k_ff;        // coordinate
   logic                   vpass_ff;    // reducing row points at v
   logic                   pend_ff;     // lerp result due
   logic [WIdxW-1:0]       pi_ff;
   logic [1:0]             pk_ff;
   logic                   pv_ff;
   coord_type              ox_ff, oy_ff, oz_ff;
   logic                   rsp_valid_ff;

   coord_type la, lb, ly;
   logic [ParamWidth-1:0] lt;
   logic [NumW-1:0] nr_sat, nc_sat;
   logic [AddrW-1:0] waddr, raddr;

   assign nr_sat = (rows_ff > 3'(MaxRows)) ? NumW'(MaxRows) : NumW'(rows_ff);
   assign nc_sat = (cols_ff > 3'(MaxCols)) ? NumW'(MaxCols) : NumW'(cols_ff);

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = ox_ff;
   assign rsp_point_y = oy_ff;
   assign rsp_point_z = oz_ff;

   assign waddr = AddrW'(32'(req_row_index) * MaxCols + 32'(req_col_index));
   assign raddr = AddrW'(32'(row_ff) * MaxCols + 32'(ld_ff));

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (req_valid && req_ready && req_operation == OP_WRITE &&
          32'(req_row_index) < MaxRows && 32'(req_col_index) < MaxCols) begin
         mem[waddr] <= {req_coord_x, req_coord_y, req_coord_z};
      end
      rd_ff <= mem[raddr];
   end

   // lerp operands: pick from row file or row point file
   always_comb begin
      lt = vpass_ff ? v_ff : u_ff;
      if (vpass_ff) begin
         la = rp_ff[RowW'(i_ff)][k_ff];
         lb = rp_ff[RowW'(i_ff + 1'b1)][k_ff];
      end else begin
         la = wx_ff[i_ff][k_ff];
         lb = wx_ff[WIdxW'(i_ff + 1'b1)][k_ff];
      end
   end

   bpe_lerp u_lerp (.clock(clock), .t(lt), .a(la), .b(lb), .y(ly));

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= 3'd4;
         cols_ff      <= 3'd4;
         rsp_valid_ff <= 1'b0;
         ld_v_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         vpass_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_ROWS: rows_ff <= csr_write_data;
               CSR_COLS: cols_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;

         // deliver the registered read into the row file
         ld_v_ff <= 1'b0;
         if (ld_v_ff) begin
            wx_ff[ld_dst_ff][0] <= rd_ff[3*CoordWidth-1 -: CoordWidth];
            wx_ff[ld_dst_ff][1] <= rd_ff[2*CoordWidth-1 -: CoordWidth];
            wx_ff[ld_dst_ff][2] <= rd_ff[CoordWidth-1:0];
         end
         // write back a finished lerp
         pend_ff <= 1'b0;
         if (pend_ff) begin
            if (pv_ff) rp_ff[RowW'(pi_ff)][pk_ff] <= ly;
            else       wx_ff[pi_ff][pk_ff] <= ly;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready && req_operation == OP_EVAL) begin
                  u_ff     <= (req_u_param > OneQ16) ? OneQ16 : req_u_param;
                  v_ff     <= (req_v_param > OneQ16) ? OneQ16 : req_v_param;
                  nr_ff    <= nr_sat;
                  nc_ff    <= nc_sat;
                  row_ff   <= '0;
                  ld_ff    <= '0;
                  vpass_ff <= 1'b0;
                  state_ff <= (nr_sat == '0) ? ST_FINAL : ST_LOAD;
                  for (int r = 0; r < MaxRows; r++)
                     for (int k = 0; k < 3; k++) rp_ff[r][k] <= '0;
               end
            end
            ST_LOAD: begin
               // read one column per cycle; empty rows leave zeros
               if (nc_ff == '0) begin
                  for (int k = 0; k < 3; k++) wx_ff[0][k] <= '0;
                  state_ff <= ST_ROWDONE;
               end else if (ld_ff < nc_ff) begin
                  ld_v_ff   <= 1'b1;
                  ld_dst_ff <= WIdxW'(ld_ff);
                  ld_ff     <= ld_ff + 1'b1;
               end else if (!ld_v_ff) begin
                  len_ff   <= nc_ff;
                  i_ff     <= '0;
                  k_ff     <= '0;
                  state_ff <= (nc_ff == NumW'(1)) ? ST_ROWDONE : ST_REDUCE;
               end
            end
            ST_REDUCE: begin
               // issue one coordinate lerp, wait for it to land
               pend_ff  <= 1'b1;
               pi_ff    <= i_ff;
               pk_ff    <= k_ff;
               pv_ff    <= vpass_ff;
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (pend_ff) begin
                  if (k_ff != 2'd2) begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= ST_REDUCE;
                  end else begin
                     k_ff <= '0;
                     if (NumW'(i_ff) + NumW'(2) < len_ff) begin
                        i_ff     <= i_ff + 1'b1;
                        state_ff <= ST_REDUCE;
                     end else if (len_ff > NumW'(2)) begin
                        i_ff     <= '0;
                        len_ff   <= len_ff - 1'b1;
                        state_ff <= ST_REDUCE;
                     end else begin
                        state_ff <= vpass_ff ? ST_FINAL : ST_ROWDONE;
                     end
                  end
               end
            end
            ST_ROWDONE: begin
               // latch the row point and advance
               for (int k = 0; k < 3; k++) rp_ff[RowW'(row_ff)][k] <= wx_ff[0][k];
               ld_ff <= '0;
               if (row_ff + 1'b1 < nr_ff) begin
                  row_ff   <= row_ff + 1'b1;
                  state_ff <= ST_LOAD;
               end else if (nr_ff > NumW'(1)) begin
                  vpass_ff <= 1'b1;
                  len_ff   <= nr_ff;
                  i_ff     <= '0;
                  k_ff     <= '0;
                  state_ff <= ST_REDUCE;
               end else begin
                  state_ff <= ST_FINAL;
               end
            end
            ST_FINAL: begin
               // row point 0 holds the result (zero when no rows);
               // hold until the previous result is taken
               if (!pend_ff && !rsp_valid_ff) begin
                  ox_ff        <= rp_ff[0][0];
                  oy_ff        <= rp_ff[0][1];
                  oz_ff        <= rp_ff[0][2];
                  rsp_valid_ff <= 1'b1;
                  vpass_ff     <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_point_x) &&
                                     $stable(rsp_point_y) && $stable(rsp_point_z)))
      else $error("result dropped or changed while stalled");
   // a write produces no result
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_operation == OP_WRITE) |=> !$rose(rsp_valid))
      else $error("result after a write");
   // result appears only when returning to idle
   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> state_ff == ST_IDLE) else $error("stray result");
endmodule
